@@ hdl/a85_pkg.sv @@
// Shared types and constants of the ASCII85 stream encoder.
package a85_pkg;

    // Characters of the encoded text.
    localparam logic [6:0] CH_LT     = 7'h3C;
    localparam logic [6:0] CH_TILDE  = 7'h7E;
    localparam logic [6:0] CH_Z      = 7'h7A;
    localparam logic [6:0] CH_GT     = 7'h3E;
    localparam logic [6:0] DIG_OFFSET = 7'd33;

    // Base of the encoding and its reciprocal, floor(2^32 / 85).
    localparam logic [6:0]  BASE  = 7'd85;
    localparam logic [25:0] RECIP = 26'd50529027;

    // Job queue between the front and the converter.
    localparam int JOB_DEPTH = 4;
    localparam int JOB_AW    = $clog2(JOB_DEPTH);

    // One job: what a single accepted byte asks the back end to emit.
    typedef struct packed {
        logic        prefix;    // open with "<~"
        logic        zero_grp;  // full all-zero group, emit 'z'
        logic [2:0]  ndig;      // number of digits to emit, 0..5
        logic        suffix;    // close with "~>"
        logic [31:0] word;      // group value, padded on the right
    } job_t;

    // One converted job: the header plus five digit characters, most
    // significant first in entry 0.
    typedef struct packed {
        logic            prefix;
        logic            zero_grp;
        logic [2:0]      ndig;
        logic            suffix;
        logic [4:0][6:0] dig;
    } conv_t;

endpackage

@@ hdl/ascii85_stream_encoder_core.sv @@
// ASCII85 stream encoder, top level: front end, job queue, converter, emitter.
// The block takes one raw byte per item and gives one encoded character per
// result item, opening each message with "<~" and closing it with "~>", the
// closing '>' flagged by last_char. Bytes enter a four-entry job queue, so a
// byte is normally taken in the cycle it is offered. The converter finds the
// base-85 digits of each group of four bytes one division at a time (a 32 by
// 26 bit reciprocal multiply, then a correction step), and it works on the
// next group while the emitter sends the previous one, one character per
// cycle while the consumer keeps taking them. A group of four zero bytes
// passes sooner, while a short final group still goes through the full
// conversion. Very short messages are limited by the emitter instead, since
// it must also send the four delimiter characters. Results are held in an
// output register and stall the input only once the job queue has filled.
module ascii85_stream_encoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] out_char,
    output logic       last_char
);
    import a85_pkg::*;

    logic  job_push;
    job_t  job_in;
    logic  job_full;
    logic  job_pop;
    job_t  job_head;
    logic  job_empty;
    logic  slot_valid;
    conv_t slot;
    logic  slot_take;

    // Byte gathering and classification.
    a85_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .job_push       (job_push),
        .job            (job_in),
        .job_full       (job_full)
    );

    // Job queue between front and back.
    a85_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_head),
        .empty   (job_empty)
    );

    // Base-85 digit conversion.
    a85_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_empty  (job_empty),
        .job_head   (job_head),
        .job_pop    (job_pop),
        .slot_valid (slot_valid),
        .slot       (slot),
        .slot_take  (slot_take)
    );

    // Character sequencing and output register.
    a85_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_valid (slot_valid),
        .slot       (slot),
        .slot_take  (slot_take),
        .empty      (empty),
        .pop        (pop),
        .out_char   (out_char),
        .last_char  (last_char)
    );

endmodule

@@ hdl/a85_front.sv @@
// Front end: gathers bytes into groups and classifies them into jobs.
module a85_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    data_byte,
    input  logic          end_of_message,
    output logic          job_push,
    output a85_pkg::job_t job,
    input  logic          job_full
);
    import a85_pkg::*;

    logic [23:0] pend_reg, pend_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        start_reg, start_next;

    logic        accept;
    logic        full_grp;
    logic [31:0] group;
    logic [2:0]  nbytes;

    assign full   = job_full;
    assign accept = push && !job_full;

    // Classify the incoming byte against the pending part of the group.
    always_comb
    begin
        group    = {pend_reg, data_byte};
        nbytes   = {1'b0, cnt_reg} + 3'd1;
        full_grp = (cnt_reg == 2'd3);

        job.prefix   = start_reg;
        job.suffix   = end_of_message;
        job.zero_grp = full_grp && (group == 32'd0);
        if (full_grp)
        begin
            job.ndig = (group == 32'd0) ? 3'd0 : 3'd5;
        end
        else if (end_of_message)
        begin
            job.ndig = nbytes + 3'd1;
        end
        else
        begin
            job.ndig = 3'd0;
        end

        case (cnt_reg)
            2'd0:    job.word = {data_byte, 24'd0};
            2'd1:    job.word = {pend_reg[7:0], data_byte, 16'd0};
            2'd2:    job.word = {pend_reg[15:0], data_byte, 8'd0};
            default: job.word = group;
        endcase

        job_push = accept && (start_reg || full_grp || end_of_message);
    end

    // Pending group state for the next byte.
    always_comb
    begin
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        if (accept)
        begin
            if (full_grp || end_of_message)
            begin
                pend_next = 24'd0;
                cnt_next  = 2'd0;
            end
            else
            begin
                pend_next = group[23:0];
                cnt_next  = cnt_reg + 2'd1;
            end
            start_next = end_of_message;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 24'd0;
            cnt_reg   <= 2'd0;
            start_reg <= 1'b1;
        end
        else
        begin
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
        end
    end

endmodule

@@ hdl/a85_fifo.sv @@
// Short job queue that decouples the front end from the converter.
module a85_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  a85_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output a85_pkg::job_t rd_data,
    output logic          empty
);
    import a85_pkg::*;

    job_t                mem_reg [JOB_DEPTH];
    logic [JOB_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [JOB_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [JOB_AW:0]     cnt_reg, cnt_next;
    logic                do_wr;
    logic                do_rd;

    assign full    = (cnt_reg == (JOB_AW+1)'(JOB_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/a85_conv.sv @@
// Converter: turns a job's group word into five base-85 digit characters.
module a85_conv (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_empty,
    input  a85_pkg::job_t  job_head,
    output logic           job_pop,
    output logic           slot_valid,
    output a85_pkg::conv_t slot,
    input  logic           slot_take
);
    import a85_pkg::*;

    localparam logic [1:0] CV_IDLE = 2'd0;
    localparam logic [1:0] CV_MUL  = 2'd1;
    localparam logic [1:0] CV_CORR = 2'd2;
    localparam logic [1:0] CV_HOLD = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [31:0] word_reg, word_next;
    logic [57:0] prod_reg, prod_next;
    logic [2:0]  idx_reg, idx_next;
    conv_t       cur_reg, cur_next;
    conv_t       slot_reg, slot_next;
    logic        slot_valid_reg, slot_valid_next;

    logic        slot_free;
    logic [31:0] mul_in;
    logic [25:0] q0;
    logic [25:0] q;
    logic [31:0] q85;
    logic [31:0] r_wide;
    logic [7:0]  r0;
    logic [7:0]  r;
    logic        corr;
    logic [4:0][6:0] dig_new;

    assign slot_free  = !slot_valid_reg || slot_take;
    assign slot_valid = slot_valid_reg;
    assign slot       = slot_reg;

    // Quotient estimate from the registered product, then one correction.
    always_comb
    begin
        q0     = prod_reg[57:32];
        q85    = 32'(q0) * 32'(BASE);
        r_wide = word_reg - q85;
        r0     = r_wide[7:0];
        corr   = (r0 >= 8'(BASE));
        r      = corr ? r0 - 8'(BASE) : r0;
        q      = q0 + 26'(corr);

        dig_new          = cur_reg.dig;
        dig_new[idx_reg] = r[6:0] + DIG_OFFSET;
        if (idx_reg == 3'd1)
        begin
            dig_new[0] = q[6:0] + DIG_OFFSET;
        end
    end

    assign mul_in = (state_reg == CV_IDLE) ? job_head.word : word_reg;

    // Sequencer: each division is a multiply (in IDLE for the first, in MUL after) then a correction in CORR.
    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        prod_next       = prod_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        slot_next       = slot_reg;
        slot_valid_next = slot_valid_reg && !slot_take;
        job_pop         = 1'b0;

        case (state_reg)
            CV_IDLE:
            begin
                if (!job_empty && (job_head.ndig != 3'd0 || slot_free))
                begin
                    job_pop           = 1'b1;
                    cur_next.prefix   = job_head.prefix;
                    cur_next.zero_grp = job_head.zero_grp;
                    cur_next.ndig     = job_head.ndig;
                    cur_next.suffix   = job_head.suffix;
                    if (job_head.ndig == 3'd0)
                    begin
                        // Nothing to convert, hand the header on at once.
                        slot_next       = cur_next;
                        slot_valid_next = 1'b1;
                    end
                    else
                    begin
                        word_next  = job_head.word;
                        prod_next  = 58'(mul_in) * 58'(RECIP);
                        idx_next   = 3'd4;
                        state_next = CV_CORR;
                    end
                end
            end
            CV_MUL:
            begin
                prod_next  = 58'(mul_in) * 58'(RECIP);
                state_next = CV_CORR;
            end
            CV_CORR:
            begin
                cur_next.dig = dig_new;
                word_next    = 32'(q);
                idx_next     = idx_reg - 3'd1;
                if (idx_reg == 3'd1)
                begin
                    if (slot_free)
                    begin
                        slot_next       = cur_next;
                        slot_valid_next = 1'b1;
                        state_next      = CV_IDLE;
                    end
                    else
                    begin
                        state_next = CV_HOLD;
                    end
                end
                else
                begin
                    state_next = CV_MUL;
                end
            end
            CV_HOLD:
            begin
                if (slot_free)
                begin
                    slot_next       = cur_reg;
                    slot_valid_next = 1'b1;
                    state_next      = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CV_IDLE;
            slot_valid_reg <= 1'b0;
            idx_reg        <= 3'd4;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            idx_reg        <= idx_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        prod_reg <= prod_next;
        cur_reg  <= cur_next;
        slot_reg <= slot_next;
    end

endmodule

@@ hdl/a85_emit.sv @@
// Emitter: steps through delimiters and digits and feeds the output register.
module a85_emit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           slot_valid,
    input  a85_pkg::conv_t slot,
    output logic           slot_take,
    output logic           empty,
    input  logic           pop,
    output logic [6:0]     out_char,
    output logic           last_char
);
    import a85_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_PRE0 = 3'd1;
    localparam logic [2:0] PH_PRE1 = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;
    localparam logic [2:0] PH_SUF0 = 3'd4;
    localparam logic [2:0] PH_SUF1 = 3'd5;

    logic [2:0] ph_reg, ph_next;
    logic [2:0] idx_reg, idx_next;
    logic       ovalid_reg, ovalid_next;
    logic [6:0] ochar_reg, ochar_next;
    logic       olast_reg, olast_next;

    logic       has_body;
    logic       after_body;
    logic [2:0] cur_ph;
    logic [2:0] nxt_ph;
    logic [6:0] ch;
    logic       ch_last;
    logic       out_free;
    logic       fire;

    assign out_free  = !ovalid_reg || pop;
    assign fire      = slot_valid && out_free;
    assign empty     = !ovalid_reg;
    assign out_char  = ochar_reg;
    assign last_char = olast_reg;

    // Pick the current character of the job and the phase after it.
    always_comb
    begin
        has_body   = slot.zero_grp || (slot.ndig != 3'd0);
        after_body = slot.suffix;
        if (ph_reg != PH_IDLE)
        begin
            cur_ph = ph_reg;
        end
        else if (slot.prefix)
        begin
            cur_ph = PH_PRE0;
        end
        else if (has_body)
        begin
            cur_ph = PH_BODY;
        end
        else
        begin
            cur_ph = PH_SUF0;
        end

        ch       = CH_LT;
        ch_last  = 1'b0;
        nxt_ph   = PH_IDLE;
        idx_next = idx_reg;

        case (cur_ph)
            PH_PRE0:
            begin
                ch     = CH_LT;
                nxt_ph = PH_PRE1;
            end
            PH_PRE1:
            begin
                ch = CH_TILDE;
                if (has_body)
                begin
                    nxt_ph = PH_BODY;
                end
                else
                begin
                    nxt_ph = after_body ? PH_SUF0 : PH_IDLE;
                end
            end
            PH_BODY:
            begin
                ch = slot.zero_grp ? CH_Z : slot.dig[idx_reg];
                if (slot.zero_grp || idx_reg == slot.ndig - 3'd1)
                begin
                    nxt_ph   = after_body ? PH_SUF0 : PH_IDLE;
                    idx_next = 3'd0;
                end
                else
                begin
                    nxt_ph   = PH_BODY;
                    idx_next = idx_reg + 3'd1;
                end
            end
            PH_SUF0:
            begin
                ch     = CH_TILDE;
                nxt_ph = PH_SUF1;
            end
            PH_SUF1:
            begin
                ch      = CH_GT;
                ch_last = 1'b1;
                nxt_ph  = PH_IDLE;
            end
            default:
            begin
                nxt_ph = PH_IDLE;
            end
        endcase
    end

    assign slot_take = fire && (nxt_ph == PH_IDLE);

    // Output register, refilled as soon as the consumer takes the item.
    always_comb
    begin
        ph_next     = ph_reg;
        ovalid_next = ovalid_reg && !pop;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        if (fire)
        begin
            ph_next     = nxt_ph;
            ovalid_next = 1'b1;
            ochar_next  = ch;
            olast_next  = ch_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg     <= PH_IDLE;
            idx_reg    <= 3'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ph_reg     <= ph_next;
            idx_reg    <= fire ? idx_next : idx_reg;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

endmodule

@@ tb/sv/a85_char_scoreboard_pkg.sv @@
// Scoreboard for the ASCII85 stream encoder: character predictor and expected-character store.
package a85_char_scoreboard_pkg;

    import a85_pkg::*;

    // One encoded character as it leaves the block.
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } enc_char_t;

    class a85_char_scoreboard;

        // Characters still owed by the block, oldest first.
        enc_char_t   owed_chars[$];

        // Predictor state: bytes of the open group, their count, and whether
        // the next byte opens a new message.
        logic [23:0] held_bytes;
        logic [1:0]  held_count;
        logic        need_open;

        int unsigned mismatches;

        function new();
            held_bytes = '0;
            held_count = '0;
            need_open  = 1'b1;
            mismatches = 0;
        endfunction

        function void owe_char(logic [6:0] ch, logic last);
            enc_char_t c;
            c.ch   = ch;
            c.last = last;
            owed_chars.push_back(c);
        endfunction

        // Queue the leading ndig base-85 digits of a group, most significant first.
        function void owe_digits(logic [31:0] grp, int ndig);
            logic [31:0] w;
            logic [6:0]  dig [5];
            w = grp;
            for (int j = 4; j >= 0; j--)
            begin
                dig[j] = 7'(w % 32'(BASE)) + DIG_OFFSET;
                w      = w / 32'(BASE);
            end
            for (int j = 0; j < ndig; j++)
            begin
                owe_char(dig[j], 1'b0);
            end
        endfunction

        // Work out the characters that one accepted byte gives rise to.
        function void note_byte(logic [7:0] data, logic eom);
            logic [31:0] grp;
            int          n;
            if (need_open)
            begin
                owe_char(CH_LT, 1'b0);
                owe_char(CH_TILDE, 1'b0);
                need_open = 1'b0;
            end
            grp = {held_bytes, data};
            n   = held_count + 1;
            if (n == 4)
            begin
                // A full group: all zeros collapse to a single 'z'.
                if (grp == '0)
                begin
                    owe_char(CH_Z, 1'b0);
                end
                else
                begin
                    owe_digits(grp, 5);
                end
                held_bytes = '0;
                held_count = '0;
            end
            else if (eom)
            begin
                // A short final group is padded with zeros and trimmed to n+1 digits.
                grp = grp << (8 * (4 - n));
                owe_digits(grp, n + 1);
                held_bytes = '0;
                held_count = '0;
            end
            else
            begin
                held_bytes = grp[23:0];
                held_count = 2'(n);
            end
            if (eom)
            begin
                owe_char(CH_TILDE, 1'b0);
                owe_char(CH_GT, 1'b1);
                held_bytes = '0;
                held_count = '0;
                need_open  = 1'b1;
            end
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Mismatch: %s", what);
            end
        endfunction

        // Compare one character taken from the block with the oldest one owed.
        function void check_char(logic [6:0] ch, logic last);
            enc_char_t want;
            if (owed_chars.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected char 0x%02h last=%0b", ch, last));
                return;
            end
            want = owed_chars.pop_front();
            if (ch !== want.ch)
            begin
                flag_mismatch($sformatf("out_char expected 0x%02h, got 0x%02h", want.ch, ch));
            end
            if (last !== want.last)
            begin
                flag_mismatch($sformatf("last_char expected %0b, got %0b", want.last, last));
            end
        endfunction

        function int owed();
            return owed_chars.size();
        endfunction

    endclass

endpackage

@@ tb/sv/testbench.sv @@
// Testbench of the ASCII85 stream encoder: directed and random messages, checked per character.
module testbench;

    import a85_char_scoreboard_pkg::*;

    // Directed messages as {end_of_message, data_byte}: single bytes at both
    // extremes, a zero group and an all-ones group that each close a message,
    // a short final group of zeros, a two-byte message, a zero group followed
    // by a one-byte tail, and a three-byte message.
    localparam logic [8:0] DIRECTED [23] = '{
        9'h100, 9'h1FF,
        9'h000, 9'h000, 9'h000, 9'h100,
        9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
        9'h000, 9'h000, 9'h100,
        9'h012, 9'h134,
        9'h000, 9'h000, 9'h000, 9'h000, 9'h101,
        9'h080, 9'h07F, 9'h155
    };

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       push           = 1'b0;
    logic       full;
    logic [7:0] data_byte      = '0;
    logic       end_of_message = 1'b0;
    logic       empty;
    logic       pop            = 1'b0;
    logic [6:0] out_char;
    logic       last_char;

    // Once set, neither side idles any more.
    logic       calm           = 1'b0;

    a85_char_scoreboard sb = new();

    ascii85_stream_encoder_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .empty          (empty),
        .pop            (pop),
        .out_char       (out_char),
        .last_char      (last_char)
    );

    always #10 clk = ~clk;

    // Watch both handshakes at each rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                sb.note_byte(data_byte, end_of_message);
            end
            if (pop && !empty)
            begin
                sb.check_char(out_char, last_char);
            end
        end
    end

    // Receiver: takes characters, with random stall bursts until the calm part.
    initial
    begin
        int hold;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && hold == 0 && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 15);
            end
            if (hold > 0)
            begin
                pop <= 1'b0;
                hold--;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Offer one byte, after an occasional idle burst, and wait until it is taken.
    task automatic send_byte(logic [7:0] data, logic eom);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        push           <= 1'b1;
        data_byte      <= data;
        end_of_message <= eom;
        do
        begin
            @(posedge clk);
        end
        while (full);
    endtask

    // Hold off the sender until every owed character has come out. The first
    // edge is waited out so that the last accepted byte has been noted.
    task automatic drain();
        push <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.owed() != 0);
    endtask

    // Byte flavors: uniform, mostly zero (to form 'z' groups), or extreme values.
    function automatic logic [7:0] pick_byte(int flavor);
        case (flavor)
            1:       return ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom);
            2:       return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Stimulus and end of run.
    initial
    begin
        int len;
        int flavor;
        int sent;
        bit drained_once;
        sent         = 0;
        drained_once = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        end
        drain();

        // Random well-formed messages, mostly short, now and then long.
        while (sent < 200)
        begin
            len    = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            flavor = $urandom_range(0, 3);
            for (int i = 0; i < len; i++)
            begin
                send_byte(pick_byte(flavor), i == len - 1);
                sent++;
            end
            if (sent >= 160)
            begin
                calm <= 1'b1;
            end
            if (!drained_once && sent >= 100)
            begin
                drain();
                drained_once = 1'b1;
            end
        end

        drain();
        repeat (40) @(posedge clk);

        if (sb.mismatches == 0 && sb.owed() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
